[design/mci_pkg.sv]
// shared types and constants for the motor command interpreter
package mci_pkg;

    // command characters
    localparam logic [7:0] CMD_STOP     = 8'h73; // s
    localparam logic [7:0] CMD_FORWARD  = 8'h75; // u
    localparam logic [7:0] CMD_BACKWARD = 8'h64; // d
    localparam logic [7:0] CMD_LEFT     = 8'h6c; // l
    localparam logic [7:0] CMD_RIGHT    = 8'h72; // r
    localparam logic [7:0] CMD_STRAIGHT = 8'h66; // f
    localparam logic [7:0] CMD_FASTER   = 8'h68; // h
    localparam logic [7:0] CMD_SLOWER   = 8'h6a; // j
    localparam logic [7:0] CMD_STEER_DN = 8'h63; // c
    localparam logic [7:0] CMD_STEER_UP = 8'h76; // v

    // configuration register indexes
    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_STEP_SIZE    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_DRIVE_DUTY   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_LEFT_ANGLE   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_RIGHT_ANGLE  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_CENTER_ANGLE = 3'd4;

    // configuration reset values
    localparam logic [7:0] RST_STEP_SIZE    = 8'd10;
    localparam logic [7:0] RST_DRIVE_DUTY   = 8'd127;
    localparam logic [7:0] RST_LEFT_ANGLE   = 8'd63;
    localparam logic [7:0] RST_RIGHT_ANGLE  = 8'd190;
    localparam logic [7:0] RST_CENTER_ANGLE = 8'd128;

    // speed values forced by stop, forward and backward, the remote neutral speed and the duty ceiling
    localparam logic [8:0] SPEED_STOP     = 9'd127;
    localparam logic [8:0] SPEED_FORWARD  = 9'd255;
    localparam logic [8:0] SPEED_BACKWARD = 9'd0;
    localparam logic [8:0] SPEED_NEUTRAL  = 9'd255;
    localparam logic [7:0] DUTY_MAX       = 8'd255;

    // result status codes
    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    // item kinds
    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_REMOTE  = 1'b1;

endpackage

[design/motor_command_interpreter.sv]
// motor command interpreter: commands and remote samples to bridge and steering duties
// a request is latched in the input register; once it can advance, its result is
// registered in the result register and shown on o_out_valid
// throughput: one request per cycle while the result side is ready, set by the single
// state update between the input register and the result register; the input register
// can hold a new request while a result waits. synchronous active-low reset clears duties,
// speed, steering, mode, valids and reloads the configuration registers with their defaults
module motor_command_interpreter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command and remote requests
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [7:0]                    i_command_byte,
    input  logic [11:0]                   i_speed_pot,
    input  logic [11:0]                   i_turn_pot,
    input  logic                          i_manual_switch,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_duty_a,
    output logic [7:0]                    o_duty_b,
    output logic [7:0]                    o_duty_c,
    output logic [7:0]                    o_duty_d,
    output logic [7:0]                    o_steer_duty,
    output logic [1:0]                    o_status,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mci_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    // configuration registers
    logic [7:0] r_step_size, r_drive_duty, r_left_angle, r_right_angle, r_center_angle;

    // input stage
    logic        r_in_valid;
    logic        r_kind;
    logic [7:0]  r_cmd;
    logic [11:0] r_spot;
    logic [11:0] r_tpot;
    logic        r_sw;

    // block state
    logic [7:0] r_a, r_b, r_c, r_d;
    logic [7:0] r_steer;
    logic [8:0] r_speed;
    logic       r_manual;

    // output stage
    logic             r_out_valid;
    logic [7:0]       r_oa, r_ob, r_oc, r_od, r_osteer;
    mci_pkg::t_status r_ostatus;

    // next values
    logic [7:0]       n_a, n_b, n_c, n_d, n_steer;
    logic [8:0]       n_speed;
    logic             n_manual;
    mci_pkg::t_status n_status;

    logic       advance;
    logic [9:0] speed_sum;
    logic [8:0] speed_up, speed_dn, speed_cmd, speed_rem;
    logic [8:0] steer_sum;
    logic [7:0] steer_up, steer_dn, drive_level;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size    <= mci_pkg::RST_STEP_SIZE;
            r_drive_duty   <= mci_pkg::RST_DRIVE_DUTY;
            r_left_angle   <= mci_pkg::RST_LEFT_ANGLE;
            r_right_angle  <= mci_pkg::RST_RIGHT_ANGLE;
            r_center_angle <= mci_pkg::RST_CENTER_ANGLE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mci_pkg::CFG_STEP_SIZE:    r_step_size    <= i_cfg_data;
                mci_pkg::CFG_DRIVE_DUTY:   r_drive_duty   <= i_cfg_data;
                mci_pkg::CFG_LEFT_ANGLE:   r_left_angle   <= i_cfg_data;
                mci_pkg::CFG_RIGHT_ANGLE:  r_right_angle  <= i_cfg_data;
                mci_pkg::CFG_CENTER_ANGLE: r_center_angle <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= i_kind;
            r_cmd  <= i_command_byte;
            r_spot <= i_speed_pot;
            r_tpot <= i_turn_pot;
            r_sw   <= i_manual_switch;
        end
    end

    // saturating speed and steering steps
    assign speed_sum = {1'b0, r_speed} + {2'b00, r_step_size};
    assign speed_up  = (speed_sum > 10'd255) ? 9'd255 : speed_sum[8:0];
    assign speed_dn  = (r_speed > {1'b0, r_step_size}) ? (r_speed - {1'b0, r_step_size})
                                                       : 9'd0;
    assign steer_sum = {1'b0, r_steer} + {1'b0, r_step_size};
    assign steer_up  = steer_sum[8] ? mci_pkg::DUTY_MAX : steer_sum[7:0];
    assign steer_dn  = (r_steer > r_step_size) ? (r_steer - r_step_size) : 8'd0;

    // speed after a nudge, and its duty clipped to the bridge range
    assign speed_cmd   = (r_cmd == mci_pkg::CMD_FASTER) ? speed_up : speed_dn;
    assign drive_level = speed_cmd[8] ? mci_pkg::DUTY_MAX : speed_cmd[7:0];

    // remote speed pot scaled to 0..511
    assign speed_rem = r_spot[11:3];

    // state update for the latched request
    always_comb begin
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_d      = r_d;
        n_steer  = r_steer;
        n_speed  = r_speed;
        n_manual = r_manual;
        n_status = mci_pkg::ST_APPLIED;
        if (r_kind == mci_pkg::KIND_REMOTE) begin
            n_manual = r_sw;
            if (r_sw) begin
                n_speed = speed_rem;
                n_steer = r_tpot[11:4];
                if (speed_rem == mci_pkg::SPEED_NEUTRAL) begin
                    n_a = 8'd0; n_b = 8'd0; n_c = 8'd0; n_d = 8'd0;
                end else if (speed_rem[8]) begin
                    n_a = speed_rem[7:0]; n_b = 8'd0; n_c = 8'd0; n_d = speed_rem[7:0];
                end else begin
                    n_a = 8'd0; n_b = ~speed_rem[7:0]; n_c = ~speed_rem[7:0]; n_d = 8'd0;
                end
            end
        end else if (r_manual) begin
            n_status = mci_pkg::ST_IGNORED;
        end else begin
            unique case (r_cmd)
                mci_pkg::CMD_STOP: begin
                    n_a = 8'd0; n_b = 8'd0; n_c = 8'd0; n_d = 8'd0;
                    n_speed = mci_pkg::SPEED_STOP;
                end
                mci_pkg::CMD_FORWARD: begin
                    n_a = r_drive_duty; n_b = 8'd0; n_c = 8'd0; n_d = r_drive_duty;
                    n_speed = mci_pkg::SPEED_FORWARD;
                end
                mci_pkg::CMD_BACKWARD: begin
                    n_a = 8'd0; n_b = r_drive_duty; n_c = r_drive_duty; n_d = 8'd0;
                    n_speed = mci_pkg::SPEED_BACKWARD;
                end
                mci_pkg::CMD_LEFT:     n_steer = r_left_angle;
                mci_pkg::CMD_RIGHT:    n_steer = r_right_angle;
                mci_pkg::CMD_STRAIGHT: n_steer = r_center_angle;
                mci_pkg::CMD_FASTER, mci_pkg::CMD_SLOWER: begin
                    n_speed = speed_cmd;
                    // direction follows the duties of switches one and two
                    if (r_a == 8'd0 && r_b == 8'd0) begin
                        n_a = 8'd0; n_b = 8'd0; n_c = 8'd0; n_d = 8'd0;
                    end else if (r_a == 8'd0) begin
                        n_b = drive_level; n_c = drive_level;
                    end else begin
                        n_a = drive_level; n_d = drive_level;
                    end
                end
                mci_pkg::CMD_STEER_DN: n_steer = steer_dn;
                mci_pkg::CMD_STEER_UP: n_steer = steer_up;
                default:               n_status = mci_pkg::ST_UNKNOWN;
            endcase
        end
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a      <= 8'd0;
            r_b      <= 8'd0;
            r_c      <= 8'd0;
            r_d      <= 8'd0;
            r_steer  <= 8'd0;
            r_speed  <= 9'd0;
            r_manual <= 1'b0;
        end else if (advance) begin
            r_a      <= n_a;
            r_b      <= n_b;
            r_c      <= n_c;
            r_d      <= n_d;
            r_steer  <= n_steer;
            r_speed  <= n_speed;
            r_manual <= n_manual;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_oa      <= n_a;
            r_ob      <= n_b;
            r_oc      <= n_c;
            r_od      <= n_d;
            r_osteer  <= n_steer;
            r_ostatus <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_duty_a     = r_oa;
    assign o_duty_b     = r_ob;
    assign o_duty_c     = r_oc;
    assign o_duty_d     = r_od;
    assign o_steer_duty = r_osteer;
    assign o_status     = r_ostatus;

    // bridge never drives both high sides at once
    a_no_shoot_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_a != 8'd0 && r_b != 8'd0))
        else $error("bridge switches one and two both driven");

    // diagonal switches always carry the same duty
    a_diagonal_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a == r_d) && (r_b == r_c))
        else $error("diagonal bridge duties differ");

    // a latched request that cannot move on stays in the input register
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("latched request lost while the result was stalled");

    // an ignored command reports ignored and leaves the bridge state as it was
    a_ignored_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_kind == mci_pkg::KIND_COMMAND && r_manual)
        |=> (r_ostatus == mci_pkg::ST_IGNORED && $stable(r_a) && $stable(r_b)))
        else $error("command in manual mode changed the bridge");

endmodule

[tb/sv/motor_command_interpreter_checker.sv]
// duty predictor and result comparison for the motor command interpreter
`timescale 1ns / 1ps

module motor_command_interpreter_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_kind,
    input  logic [7:0]                  i_command_byte,
    input  logic [11:0]                 i_speed_pot,
    input  logic [11:0]                 i_turn_pot,
    input  logic                        i_manual_switch,
    // result channel
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [7:0]                  i_duty_a,
    input  logic [7:0]                  i_duty_b,
    input  logic [7:0]                  i_duty_c,
    input  logic [7:0]                  i_duty_d,
    input  logic [7:0]                  i_steer_duty,
    input  logic [1:0]                  i_status,
    // register write channel
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [mci_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [7:0]                  i_cfg_data,
    // to the test top
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] duty_a;
        logic [7:0] duty_b;
        logic [7:0] duty_c;
        logic [7:0] duty_d;
        logic [7:0] steer;
        logic [1:0] status;
    } t_drive_state;

    // model copy of the car state and the register file
    logic [7:0] bridge [4];
    logic [7:0] steer_val;
    logic [8:0] speed_val;
    logic       manual_on;
    logic [7:0] step_reg;
    logic [7:0] drive_reg;
    logic [7:0] left_reg;
    logic [7:0] right_reg;
    logic [7:0] center_reg;

    t_drive_state pending_duties [$];
    int           mismatch_total;

    function automatic void set_bridge(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
        bridge[0] = a;
        bridge[1] = b;
        bridge[2] = c;
        bridge[3] = d;
    endfunction

    // h and j keep the direction the bridge is already driving in
    function automatic void follow_direction();
        logic [7:0] duty;
        duty = (speed_val > 9'd255) ? mci_pkg::DUTY_MAX : speed_val[7:0];
        if (bridge[0] == 8'd0 && bridge[1] == 8'd0) begin
            set_bridge(8'd0, 8'd0, 8'd0, 8'd0);
        end else if (bridge[0] == 8'd0) begin
            bridge[1] = duty;
            bridge[2] = duty;
        end else begin
            bridge[0] = duty;
            bridge[3] = duty;
        end
    endfunction

    // advance the car state by one request and return the duties it leaves
    function automatic t_drive_state drive_after_request(input logic kind,
                                                         input logic [7:0] cmd,
                                                         input logic [11:0] spot,
                                                         input logic [11:0] tpot,
                                                         input logic sw);
        t_drive_state     res;
        mci_pkg::t_status st;
        int               sum;
        st = mci_pkg::ST_APPLIED;
        if (kind == mci_pkg::KIND_COMMAND) begin
            if (manual_on) begin
                st = mci_pkg::ST_IGNORED;
            end else begin
                case (cmd)
                    mci_pkg::CMD_STOP: begin
                        set_bridge(8'd0, 8'd0, 8'd0, 8'd0);
                        speed_val = mci_pkg::SPEED_STOP;
                    end
                    mci_pkg::CMD_FORWARD: begin
                        set_bridge(drive_reg, 8'd0, 8'd0, drive_reg);
                        speed_val = mci_pkg::SPEED_FORWARD;
                    end
                    mci_pkg::CMD_BACKWARD: begin
                        set_bridge(8'd0, drive_reg, drive_reg, 8'd0);
                        speed_val = mci_pkg::SPEED_BACKWARD;
                    end
                    mci_pkg::CMD_LEFT:     steer_val = left_reg;
                    mci_pkg::CMD_RIGHT:    steer_val = right_reg;
                    mci_pkg::CMD_STRAIGHT: steer_val = center_reg;
                    mci_pkg::CMD_FASTER: begin
                        sum = int'(speed_val) + int'(step_reg);
                        speed_val = (sum > 255) ? 9'd255 : 9'(sum);
                        follow_direction();
                    end
                    mci_pkg::CMD_SLOWER: begin
                        speed_val = (speed_val > {1'b0, step_reg}) ?
                                    speed_val - {1'b0, step_reg} : 9'd0;
                        follow_direction();
                    end
                    mci_pkg::CMD_STEER_DN: begin
                        steer_val = (steer_val > step_reg) ? steer_val - step_reg : 8'd0;
                    end
                    mci_pkg::CMD_STEER_UP: begin
                        sum = int'(steer_val) + int'(step_reg);
                        steer_val = (sum > 255) ? 8'd255 : 8'(sum);
                    end
                    default: st = mci_pkg::ST_UNKNOWN;
                endcase
            end
        end else begin
            // remote sample: mode follows the switch, pots map straight through
            manual_on = sw;
            if (sw) begin
                speed_val = spot[11:3];
                steer_val = tpot[11:4];
                if (speed_val == mci_pkg::SPEED_NEUTRAL) begin
                    set_bridge(8'd0, 8'd0, 8'd0, 8'd0);
                end else if (speed_val > mci_pkg::SPEED_NEUTRAL) begin
                    set_bridge(speed_val[7:0], 8'd0, 8'd0, speed_val[7:0]);
                end else begin
                    set_bridge(8'd0, mci_pkg::DUTY_MAX - speed_val[7:0],
                               mci_pkg::DUTY_MAX - speed_val[7:0], 8'd0);
                end
            end
        end
        res.duty_a = bridge[0];
        res.duty_b = bridge[1];
        res.duty_c = bridge[2];
        res.duty_d = bridge[3];
        res.steer  = steer_val;
        res.status = st;
        return res;
    endfunction

    // watch all three channels at each edge
    always @(posedge i_clk) begin : watch
        t_drive_state got;
        t_drive_state want;
        if (!i_rst_n) begin
            set_bridge(8'd0, 8'd0, 8'd0, 8'd0);
            steer_val  = 8'd0;
            speed_val  = 9'd0;
            manual_on  = 1'b0;
            step_reg   = mci_pkg::RST_STEP_SIZE;
            drive_reg  = mci_pkg::RST_DRIVE_DUTY;
            left_reg   = mci_pkg::RST_LEFT_ANGLE;
            right_reg  = mci_pkg::RST_RIGHT_ANGLE;
            center_reg = mci_pkg::RST_CENTER_ANGLE;
            pending_duties.delete();
            mismatch_total = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mci_pkg::CFG_STEP_SIZE:    step_reg   = i_cfg_data;
                    mci_pkg::CFG_DRIVE_DUTY:   drive_reg  = i_cfg_data;
                    mci_pkg::CFG_LEFT_ANGLE:   left_reg   = i_cfg_data;
                    mci_pkg::CFG_RIGHT_ANGLE:  right_reg  = i_cfg_data;
                    mci_pkg::CFG_CENTER_ANGLE: center_reg = i_cfg_data;
                    default: ;
                endcase
            end
            // results against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got = '{i_duty_a, i_duty_b, i_duty_c, i_duty_d, i_steer_duty, i_status};
                if (pending_duties.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= MAX_REPORTS) begin
                        $display({"unexpected result: a=%0d b=%0d c=%0d d=%0d",
                                  " steer=%0d status=%0d"},
                                 got.duty_a, got.duty_b, got.duty_c, got.duty_d,
                                 got.steer, got.status);
                    end
                end else begin
                    want = pending_duties.pop_front();
                    if (got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
                        got.duty_c !== want.duty_c || got.duty_d !== want.duty_d ||
                        got.steer !== want.steer || got.status !== want.status) begin
                        mismatch_total++;
                        if (mismatch_total <= MAX_REPORTS) begin
                            $display({"mismatch at %0t: expected a=%0d b=%0d c=%0d d=%0d",
                                      " steer=%0d status=%0d"},
                                     $realtime, want.duty_a, want.duty_b, want.duty_c,
                                     want.duty_d, want.steer, want.status);
                            $display({"                 actual a=%0d b=%0d c=%0d d=%0d",
                                      " steer=%0d status=%0d"},
                                     got.duty_a, got.duty_b, got.duty_c, got.duty_d,
                                     got.steer, got.status);
                        end
                    end
                end
            end
            // accepted requests
            if (i_in_valid && i_in_ready) begin
                pending_duties.push_back(drive_after_request(i_kind, i_command_byte,
                                                             i_speed_pot, i_turn_pot,
                                                             i_manual_switch));
            end
            o_fail_count <= mismatch_total;
            o_pending    <= pending_duties.size();
        end
    end

endmodule

[tb/sv/motor_command_interpreter_test.sv]
// stimulus, flow control and verdict for the motor command interpreter
`timescale 1ns / 1ps

module motor_command_interpreter_test;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASE_REQUESTS = 140;
    localparam int NUM_PHASES     = 5;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_START_A   = 400;
    localparam int HOLD_START_B   = 1500;
    localparam int HOLD_CYCLES    = 60;
    localparam int IDX_W          = mci_pkg::CfgIdxW;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic             kind = mci_pkg::KIND_COMMAND;
    logic [7:0]       command_byte = 8'd0;
    logic [11:0]      speed_pot = 12'd0;
    logic [11:0]      turn_pot = 12'd0;
    logic             manual_switch = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       duty_a;
    logic [7:0]       duty_b;
    logic [7:0]       duty_c;
    logic [7:0]       duty_d;
    logic [7:0]       steer_duty;
    logic [1:0]       status;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = mci_pkg::CFG_STEP_SIZE;
    logic [7:0]       cfg_data = 8'd0;
    logic             steady = 1'b0;
    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    int               recv_cycles = 0;
    int               hold_left = 0;

    always #6 clk = ~clk;

    motor_command_interpreter dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_kind          (kind),
        .i_command_byte  (command_byte),
        .i_speed_pot     (speed_pot),
        .i_turn_pot      (turn_pot),
        .i_manual_switch (manual_switch),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_duty_a        (duty_a),
        .o_duty_b        (duty_b),
        .o_duty_c        (duty_c),
        .o_duty_d        (duty_d),
        .o_steer_duty    (steer_duty),
        .o_status        (status),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    motor_command_interpreter_checker duty_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_kind          (kind),
        .i_command_byte  (command_byte),
        .i_speed_pot     (speed_pot),
        .i_turn_pot      (turn_pot),
        .i_manual_switch (manual_switch),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_duty_a        (duty_a),
        .i_duty_b        (duty_b),
        .i_duty_c        (duty_c),
        .i_duty_d        (duty_d),
        .i_steer_duty    (steer_duty),
        .i_status        (status),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("motor_command_interpreter regression: fail");
            $finish;
        end
    end

    // result side: random stalls plus two long hold-offs that back up the block
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            recv_cycles <= recv_cycles + 1;
            if (recv_cycles == HOLD_START_A || recv_cycles == HOLD_START_B) begin
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= steady || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    function automatic bit sender_idles();
        return !steady && ($urandom_range(0, 99) < 22);
    endfunction

    function automatic logic [7:0] known_command(input int n);
        case (n)
            0:       return mci_pkg::CMD_STOP;
            1:       return mci_pkg::CMD_FORWARD;
            2:       return mci_pkg::CMD_BACKWARD;
            3:       return mci_pkg::CMD_LEFT;
            4:       return mci_pkg::CMD_RIGHT;
            5:       return mci_pkg::CMD_STRAIGHT;
            6:       return mci_pkg::CMD_FASTER;
            7:       return mci_pkg::CMD_SLOWER;
            8:       return mci_pkg::CMD_STEER_DN;
            default: return mci_pkg::CMD_STEER_UP;
        endcase
    endfunction

    // one request; valid drops only when a gap is taken
    task automatic send_request(input logic k, input logic [7:0] cmd, input logic [11:0] spot,
                                input logic [11:0] tpot, input logic sw);
        if (sender_idles()) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (sender_idles());
        end
        in_valid      <= 1'b1;
        kind          <= k;
        command_byte  <= cmd;
        speed_pot     <= spot;
        turn_pot      <= tpot;
        manual_switch <= sw;
        do @(posedge clk); while (!in_ready);
    endtask

    // command byte with random filler in the unused fields
    task automatic send_command(input logic [7:0] cmd);
        send_request(mci_pkg::KIND_COMMAND, cmd, 12'($urandom), 12'($urandom),
                     1'($urandom));
    endtask

    task automatic send_remote(input logic [11:0] spot, input logic [11:0] tpot, input logic sw);
        send_request(mci_pkg::KIND_REMOTE, 8'($urandom), spot, tpot, sw);
    endtask

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 24) begin
            send_remote(12'($urandom), 12'($urandom), $urandom_range(0, 99) < 35);
        end else if (pick < 34) begin
            send_command(8'($urandom));
        end else begin
            send_command(known_command($urandom_range(0, 9)));
        end
    endtask

    // let every outstanding result come back, then let the pipeline settle
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_settings(input logic [7:0] step, input logic [7:0] drive,
                                    input logic [7:0] left, input logic [7:0] right,
                                    input logic [7:0] center);
        write_register(mci_pkg::CFG_STEP_SIZE, step);
        write_register(mci_pkg::CFG_DRIVE_DUTY, drive);
        write_register(mci_pkg::CFG_LEFT_ANGLE, left);
        write_register(mci_pkg::CFG_RIGHT_ANGLE, right);
        // an index past the register file must be ignored
        write_register(IDX_W'($urandom_range(mci_pkg::CFG_CENTER_ANGLE + 1,
                                             (1 << IDX_W) - 1)),
                       8'($urandom));
        write_register(mci_pkg::CFG_CENTER_ANGLE, center);
    endtask

    // stimulus and verdict
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass under reset settings
        send_remote(12'hfff, 12'hfff, 1'b0);
        send_command(mci_pkg::CMD_FASTER);
        send_command(mci_pkg::CMD_FORWARD);
        send_command(mci_pkg::CMD_FASTER);
        send_command(mci_pkg::CMD_SLOWER);
        send_command(mci_pkg::CMD_BACKWARD);
        send_command(mci_pkg::CMD_SLOWER);
        send_command(mci_pkg::CMD_FASTER);
        send_command(mci_pkg::CMD_STOP);
        send_command(mci_pkg::CMD_LEFT);
        send_command(mci_pkg::CMD_RIGHT);
        send_command(mci_pkg::CMD_STRAIGHT);
        send_command(mci_pkg::CMD_STEER_DN);
        send_command(mci_pkg::CMD_STEER_UP);
        send_command(8'h00);
        send_command(8'hff);
        send_remote(12'hfff, 12'hfff, 1'b1);
        send_command(mci_pkg::CMD_FORWARD);
        // speed exactly neutral, then just above it
        send_remote(12'd2040, 12'd2047, 1'b1);
        send_remote(12'd2048, 12'd2048, 1'b1);
        send_remote(12'd0, 12'd0, 1'b1);
        send_remote(12'hfff, 12'hfff, 1'b1);
        send_remote(12'd0, 12'd0, 1'b0);
        // speed above duty range still held: slowing saturates the duty
        send_command(mci_pkg::CMD_SLOWER);
        send_command(mci_pkg::CMD_FASTER);

        // random phases, each under its own register settings
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0:       program_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                1:       program_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                2:       program_settings(8'd1, 8'($urandom), 8'($urandom), 8'($urandom),
                                          8'($urandom));
                default: program_settings(8'($urandom_range(0, 40)), 8'($urandom),
                                          8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            // one phase runs with no idling on either side
            steady <= (phase == 2);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                send_random_request();
            end
        end

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("motor_command_interpreter regression: pass");
        end else begin
            $display("motor_command_interpreter regression: fail");
        end
        $finish;
    end

endmodule
